[rtl/wli_pkg.sv]
// Shared constants, codes and types of the waypoint linear interpolator.
package wli_pkg;

    localparam int JOINTS      = 14;
    localparam int WAYPOINTS   = 64;
    localparam int TABLE_DEPTH = WAYPOINTS * JOINTS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ROW_W       = $clog2(WAYPOINTS);
    localparam int JOINT_W     = 4;
    localparam int COUNT_W     = 7;
    localparam int POS_W       = 32;
    localparam int DIFF_W      = POS_W + 1;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int FRAC_W      = 25;
    localparam int FMUL_W      = 24;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int MUL_W       = DIFF_W + FMUL_W + 1;

    localparam logic [FRAC_W-1:0] ONE_Q24 = FRAC_W'(16777216);

    localparam logic [CFG_W-1:0] SPEED_RST     = CFG_W'(13107);
    localparam logic [CFG_W-1:0] TIME_STEP_RST = CFG_W'(16777);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_REACHED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b1;

    // per-beat tag that travels with table reads through the blend pipeline
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic               last;
        logic               zero;
    } wli_tag_t;

    function automatic logic [ADDR_W-1:0] table_addr(input logic [ROW_W-1:0] row,
                                                     input logic [JOINT_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(JOINTS) + ADDR_W'(col);
    endfunction

endpackage

[rtl/waypoint_linear_interpolator.sv]
// Waypoint linear interpolator: sequencer, start scan, trajectory state and result register.
//
// Usage: an input beat (valid/ready) carries one operation. A load writes one
// joint coordinate of one waypoint row into the table; a clear stops the
// trajectory; a start with two or more waypoints scans the first segment
// for its largest joint difference and derives the fraction step; a tick
// returns one result beat per joint, blending the current segment.
// Load, clear and start return one result beat each with last set.
// One item at a time; ready is high only between items. A tick issues one
// table read pair per joint and then drains the read and blend pipeline.
// A start scans one read pair per joint and then runs the serial divider,
// unless its first segment has no motion; empty and single-waypoint starts
// skip the scan and go straight to their result beat.
// Results sit in an output register; while the receiver stalls the table
// reads and blend pipeline hold in place and nothing is lost.
// Reset clears the trajectory (reached set, step 1.0) and loads the default
// speed and time step; table contents are undefined until loaded.
// Configuration writes land at once; the user must make them only while idle (unenforced).
module waypoint_linear_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wli_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wli_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [wli_pkg::ROW_W-1:0]     waypoint_index,
    input  logic [wli_pkg::JOINT_W-1:0]   joint_index,
    input  logic [wli_pkg::POS_W-1:0]     coordinate,
    input  logic [wli_pkg::COUNT_W-1:0]   waypoint_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wli_pkg::JOINT_W-1:0]   joint_out,
    output logic [wli_pkg::POS_W-1:0]     position,
    output logic                          last,
    output logic [1:0]                    status
);
    import wli_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EMIT  = 3'd1;
    localparam logic [2:0] ST_TICK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_MAXW  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CFG_W-1:0]   speed_reg;
    logic [CFG_W-1:0]   time_step_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ROW_W-1:0]   segment_reg, segment_next;
    logic [ROW_W-1:0]   seg_count_reg, seg_count_next;
    logic [FRAC_W-1:0]  fraction_reg, fraction_next;
    logic [FRAC_W-1:0]  step_reg, step_next;
    logic               reached_reg, reached_next;
    logic [JOINT_W-1:0] j_reg, j_next;
    logic [1:0]         emit_status_reg, emit_status_next;
    logic [POS_W-1:0]   max_reg, max_next;

    logic               s1_v_reg;
    wli_tag_t           s1_tag_reg;
    logic               absd_v_reg;
    logic               absd_last_reg;
    logic [POS_W-1:0]   absd_reg;

    logic               out_v_reg, out_v_next;
    logic [JOINT_W-1:0] out_joint_reg, out_joint_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               out_last_reg, out_last_next;
    logic [1:0]         out_status_reg, out_status_next;

    logic               in_fire;
    logic               adv;
    logic               tick_mode;
    logic               scan_mode;
    logic               pipe_en;
    logic               issuing;
    logic               ram_we;
    logic [ADDR_W-1:0]  waddr;
    logic [ROW_W-1:0]   row_a;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
    logic [POS_W-1:0]   rdata_a;
    logic [POS_W-1:0]   rdata_b;
    wli_tag_t           issue_tag;

    logic [DIFF_W-1:0]  up_diff;
    logic [DIFF_W-1:0]  dn_diff;
    logic [POS_W-1:0]   mx_next;
    logic               fin;

    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  quotient;

    logic               b_valid;
    wli_tag_t           b_tag;
    logic [POS_W-1:0]   b_pos;

    logic [COUNT_W-1:0] cnt_clamped;
    logic [COUNT_W-1:0] cnt_m1;
    logic [FRAC_W-1:0]  frac_sum;
    logic [ROW_W-1:0]   seg_p1;

    assign in_ready  = state_reg == ST_IDLE;
    assign in_fire   = in_valid && in_ready;
    assign adv       = !out_v_reg || out_ready;
    assign tick_mode = state_reg == ST_TICK || state_reg == ST_DRAIN;
    assign scan_mode = state_reg == ST_SCAN || state_reg == ST_MAXW;
    // ticks stall with the output register; the start scan never does
    assign pipe_en   = tick_mode ? adv : 1'b1;
    assign issuing   = state_reg == ST_TICK || state_reg == ST_SCAN;

    assign ram_we = in_fire && operation == OP_LOAD
                    && {1'b0, waypoint_index} < COUNT_W'(WAYPOINTS)
                    && joint_index < JOINT_W'(JOINTS);
    assign waddr  = table_addr(waypoint_index, joint_index);
    assign row_a  = scan_mode ? '0 : segment_reg;
    assign raddr_a = table_addr(row_a, j_reg);
    assign raddr_b = table_addr(row_a + ROW_W'(1), j_reg);

    assign issue_tag.joint = j_reg;
    assign issue_tag.last  = j_reg == JOINT_W'(JOINTS - 1);
    assign issue_tag.zero  = reached_reg;

    wli_table u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (coordinate),
        .re      (pipe_en && issuing),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    wli_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s1_v_reg && tick_mode),
        .in_tag    (s1_tag_reg),
        .p0        (rdata_a),
        .p1        (rdata_b),
        .frac      (fraction_reg[FMUL_W-1:0]),
        .out_valid (b_valid),
        .out_tag   (b_tag),
        .out_pos   (b_pos)
    );

    wli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mx_next),
        .done     (div_done),
        .quotient (quotient)
    );

    // start scan: absolute joint difference of the first segment, then running max
    assign up_diff = {1'b0, rdata_b} - {1'b0, rdata_a};
    assign dn_diff = {1'b0, rdata_a} - {1'b0, rdata_b};
    assign mx_next = (absd_v_reg && absd_reg > max_reg) ? absd_reg : max_reg;
    assign fin     = state_reg == ST_MAXW && absd_v_reg && absd_last_reg;
    assign div_start = fin && mx_next != '0;

    assign cnt_clamped = waypoint_count > COUNT_W'(WAYPOINTS) ? COUNT_W'(WAYPOINTS)
                                                              : waypoint_count;
    assign cnt_m1   = cnt_clamped - COUNT_W'(1);
    assign frac_sum = fraction_reg + step_reg;
    assign seg_p1   = segment_reg + ROW_W'(1);

    always_ff @(posedge clk)
    begin
        prod_reg <= time_step_reg * speed_reg;
        if (pipe_en)
        begin
            s1_tag_reg <= issue_tag;
        end
        absd_last_reg <= s1_tag_reg.last;
        if ($signed(rdata_b) >= $signed(rdata_a))
        begin
            absd_reg <= up_diff[POS_W-1:0];
        end
        else
        begin
            absd_reg <= dn_diff[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= SPEED_RST;
            time_step_reg <= TIME_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SPEED:     speed_reg     <= cfg_data;
                CFG_TIME_STEP: time_step_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        segment_next     = segment_reg;
        seg_count_next   = seg_count_reg;
        fraction_next    = fraction_reg;
        step_next        = step_reg;
        reached_next     = reached_reg;
        j_next           = j_reg;
        emit_status_next = emit_status_reg;
        max_next         = absd_v_reg ? mx_next : max_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    emit_status_next = STATUS_OK;
                    j_next           = '0;
                    case (operation)
                        OP_LOAD:
                        begin
                            state_next = ST_EMIT;
                        end
                        OP_CLEAR:
                        begin
                            reached_next   = 1'b1;
                            segment_next   = '0;
                            seg_count_next = '0;
                            fraction_next  = '0;
                            state_next     = ST_EMIT;
                        end
                        OP_START:
                        begin
                            if (waypoint_count == '0)
                            begin
                                emit_status_next = STATUS_EMPTY;
                                state_next       = ST_EMIT;
                            end
                            else
                            begin
                                segment_next   = '0;
                                fraction_next  = '0;
                                seg_count_next = cnt_m1[ROW_W-1:0];
                                if (cnt_m1 == '0)
                                begin
                                    reached_next     = 1'b1;
                                    emit_status_next = STATUS_REACHED;
                                    state_next       = ST_EMIT;
                                end
                                else
                                begin
                                    reached_next = 1'b0;
                                    max_next     = '0;
                                    state_next   = ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_TICK;
                        end
                    endcase
                end
            end
            ST_TICK, ST_SCAN:
            begin
                if (pipe_en)
                begin
                    j_next = j_reg + JOINT_W'(1);
                    if (issue_tag.last)
                    begin
                        state_next = (state_reg == ST_TICK) ? ST_DRAIN : ST_MAXW;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (adv && b_valid && b_tag.last)
                begin
                    state_next = ST_IDLE;
                    if (!reached_reg)
                    begin
                        if (frac_sum >= ONE_Q24)
                        begin
                            fraction_next = '0;
                            if (seg_p1 >= seg_count_reg)
                            begin
                                reached_next = 1'b1;
                                segment_next = seg_count_reg - ROW_W'(1);
                            end
                            else
                            begin
                                segment_next = seg_p1;
                            end
                        end
                        else
                        begin
                            fraction_next = frac_sum;
                        end
                    end
                end
            end
            ST_MAXW:
            begin
                if (fin)
                begin
                    if (mx_next == '0)
                    begin
                        step_next  = ONE_Q24;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    step_next  = (quotient > PROD_W'(ONE_Q24)) ? ONE_Q24
                                                               : quotient[FRAC_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register: single beats from the sequencer, joint beats from the blend
    always_comb
    begin
        out_v_next      = out_v_reg && !out_ready;
        out_joint_next  = out_joint_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (adv)
        begin
            if (state_reg == ST_EMIT)
            begin
                out_v_next      = 1'b1;
                out_joint_next  = '0;
                out_pos_next    = '0;
                out_last_next   = 1'b1;
                out_status_next = emit_status_reg;
            end
            else if (b_valid)
            begin
                out_v_next      = 1'b1;
                out_joint_next  = b_tag.joint;
                out_pos_next    = b_pos;
                out_last_next   = b_tag.last;
                out_status_next = b_tag.zero ? STATUS_REACHED : STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            segment_reg     <= '0;
            seg_count_reg   <= '0;
            fraction_reg    <= '0;
            step_reg        <= ONE_Q24;
            reached_reg     <= 1'b1;
            j_reg           <= '0;
            emit_status_reg <= STATUS_OK;
            max_reg         <= '0;
            s1_v_reg        <= 1'b0;
            absd_v_reg      <= 1'b0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            segment_reg     <= segment_next;
            seg_count_reg   <= seg_count_next;
            fraction_reg    <= fraction_next;
            step_reg        <= step_next;
            reached_reg     <= reached_next;
            j_reg           <= j_next;
            emit_status_reg <= emit_status_next;
            max_reg         <= max_next;
            if (pipe_en)
            begin
                s1_v_reg <= issuing;
            end
            absd_v_reg      <= s1_v_reg && scan_mode;
            out_v_reg       <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_joint_reg  <= out_joint_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_v_reg;
    assign joint_out = out_joint_reg;
    assign position  = out_pos_reg;
    assign last      = out_last_reg;
    assign status    = out_status_reg;

endmodule

[rtl/wli_table.sv]
// Waypoint coordinate table: one write port, two registered read ports.
module wli_table (
    input  logic                      clk,
    input  logic                      we,
    input  logic [wli_pkg::ADDR_W-1:0] waddr,
    input  logic [wli_pkg::POS_W-1:0]  wdata,
    input  logic                      re,
    input  logic [wli_pkg::ADDR_W-1:0] raddr_a,
    input  logic [wli_pkg::ADDR_W-1:0] raddr_b,
    output logic [wli_pkg::POS_W-1:0]  rdata_a,
    output logic [wli_pkg::POS_W-1:0]  rdata_b
);
    import wli_pkg::*;

    logic [POS_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low so a stalled pipeline keeps its operands
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[rtl/wli_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module wli_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wli_pkg::PROD_W-1:0] dividend,
    input  logic [wli_pkg::POS_W-1:0]  divisor,
    output logic                       done,
    output logic [wli_pkg::PROD_W-1:0] quotient
);
    import wli_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0] n_reg;
    logic [PROD_W-1:0] q_reg;
    logic [POS_W-1:0]  d_reg;
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, n_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[PROD_W-2:0], 1'b0};
            q_reg   <= {q_reg[PROD_W-2:0], fits};
            rem_reg <= fits ? POS_W'(trial - {1'b0, d_reg}) : trial[POS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/wli_blend.sv]
// Blend pipeline: difference, fraction multiply, rounding and offset add.
module wli_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  wli_pkg::wli_tag_t           in_tag,
    input  logic [wli_pkg::POS_W-1:0]   p0,
    input  logic [wli_pkg::POS_W-1:0]   p1,
    input  logic [wli_pkg::FMUL_W-1:0]  frac,
    output logic                        out_valid,
    output wli_pkg::wli_tag_t           out_tag,
    output logic [wli_pkg::POS_W-1:0]   out_pos
);
    import wli_pkg::*;

    logic                     a_v_reg;
    wli_tag_t                 a_tag_reg;
    logic [POS_W-1:0]         a_p0_reg;
    logic signed [DIFF_W-1:0] a_diff_reg;

    logic                     b_v_reg;
    wli_tag_t                 b_tag_reg;
    logic [POS_W-1:0]         b_p0_reg;
    logic signed [MUL_W-1:0]  b_prod_reg;

    logic signed [MUL_W-1:0]  mul;
    logic signed [MUL_W-1:0]  rounded;

    assign mul     = a_diff_reg * $signed({1'b0, frac});
    assign rounded = b_prod_reg + MUL_W'(1 << 23);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_tag_reg  <= in_tag;
            a_p0_reg   <= p0;
            a_diff_reg <= $signed({p1[POS_W-1], p1}) - $signed({p0[POS_W-1], p0});
            b_tag_reg  <= a_tag_reg;
            b_p0_reg   <= a_p0_reg;
            b_prod_reg <= mul;
        end
    end

    // the blended value lies between p0 and p1, so modulo-2^32 arithmetic is exact
    assign out_valid = b_v_reg;
    assign out_tag   = b_tag_reg;
    assign out_pos   = b_tag_reg.zero ? '0 : b_p0_reg + rounded[POS_W+23:24];

endmodule

[sim/tb.sv]
// Self-checking testbench for the waypoint linear interpolator: directed and random traffic.
module tb;
    import wli_pkg::*;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [POS_W-1:0]   pos;
        logic               last;
        logic [1:0]         status;
    } position_beat_t;

    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_SPEED;
    logic [CFG_W-1:0]     cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [1:0]           operation      = OP_LOAD;
    logic [ROW_W-1:0]     waypoint_index = '0;
    logic [JOINT_W-1:0]   joint_index    = '0;
    logic [POS_W-1:0]     coordinate     = '0;
    logic [COUNT_W-1:0]   waypoint_count = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [JOINT_W-1:0]   joint_out;
    logic [POS_W-1:0]     position;
    logic                 last;
    logic [1:0]           status;

    // shadow of the block: table, trajectory and registers
    logic [POS_W-1:0] shadow_table [TABLE_DEPTH];
    bit               loaded       [TABLE_DEPTH];
    int unsigned      traj_segment;
    int unsigned      traj_segments;
    int unsigned      traj_fraction;
    int unsigned      traj_step;
    bit               traj_reached;
    longint unsigned  speed_reg;
    longint unsigned  time_step_reg;

    position_beat_t pending_positions [$];
    int  errors;
    int  beats_checked;
    int  items_sent;
    int  ticks_sent;
    int  starts_sent;
    bit  calm;

    waypoint_linear_interpolator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .waypoint_index (waypoint_index),
        .joint_index    (joint_index),
        .coordinate     (coordinate),
        .waypoint_count (waypoint_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .joint_out      (joint_out),
        .position       (position),
        .last           (last),
        .status         (status)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 27);
    end

    function automatic longint table_entry(input int unsigned row, input int unsigned col);
        return longint'($signed(shadow_table[row * JOINTS + col]));
    endfunction

    function automatic bit row_loaded(input int unsigned row);
        for (int j = 0; j < JOINTS; j++)
        begin
            if (!loaded[row * JOINTS + j])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected result beats of one accepted item; updates the shadow state
    task automatic predict_positions(input logic [1:0] op, input int row, input int col,
                                     input logic [POS_W-1:0] coord, input int cnt);
        longint          maxdiff;
        longint          d;
        longint          p0;
        longint          p1;
        longint          prod;
        longint unsigned quot;
        int unsigned     n;
        maxdiff = 0;
        case (op)
            OP_LOAD:
            begin
                if (col < JOINTS)
                begin
                    shadow_table[row * JOINTS + col] = coord;
                    loaded[row * JOINTS + col]       = 1'b1;
                end
                pending_positions.push_back(position_beat_t'{'0, '0, 1'b1, STATUS_OK});
            end
            OP_CLEAR:
            begin
                traj_reached  = 1'b1;
                traj_segment  = 0;
                traj_segments = 0;
                traj_fraction = 0;
                pending_positions.push_back(position_beat_t'{'0, '0, 1'b1, STATUS_OK});
            end
            OP_START:
            begin
                if (cnt == 0)
                begin
                    pending_positions.push_back(position_beat_t'{'0, '0, 1'b1, STATUS_EMPTY});
                end
                else
                begin
                    n             = (cnt > WAYPOINTS) ? WAYPOINTS : cnt;
                    traj_segment  = 0;
                    traj_fraction = 0;
                    traj_segments = n - 1;
                    if (traj_segments == 0)
                    begin
                        traj_reached = 1'b1;
                        pending_positions.push_back(
                            position_beat_t'{'0, '0, 1'b1, STATUS_REACHED});
                    end
                    else
                    begin
                        traj_reached = 1'b0;
                        for (int j = 0; j < JOINTS; j++)
                        begin
                            d = table_entry(1, j) - table_entry(0, j);
                            if (d < 0)
                                d = -d;
                            if (d > maxdiff)
                                maxdiff = d;
                        end
                        if (maxdiff == 0)
                        begin
                            traj_step = ONE_Q24;
                        end
                        else
                        begin
                            quot      = (time_step_reg * speed_reg) / longint'(maxdiff);
                            traj_step = (quot > ONE_Q24) ? ONE_Q24 : int'(quot);
                        end
                        pending_positions.push_back(
                            position_beat_t'{'0, '0, 1'b1, STATUS_OK});
                    end
                end
            end
            default:
            begin
                if (traj_reached)
                begin
                    for (int j = 0; j < JOINTS; j++)
                        pending_positions.push_back(position_beat_t'{JOINT_W'(j), '0,
                            j == JOINTS - 1, STATUS_REACHED});
                end
                else
                begin
                    for (int j = 0; j < JOINTS; j++)
                    begin
                        p0   = table_entry(traj_segment, j);
                        p1   = table_entry(traj_segment + 1, j);
                        prod = (p1 - p0) * longint'(traj_fraction) + (longint'(1) << 23);
                        pending_positions.push_back(position_beat_t'{JOINT_W'(j),
                            POS_W'(p0 + (prod >>> 24)), j == JOINTS - 1, STATUS_OK});
                    end
                    traj_fraction = traj_fraction + traj_step;
                    if (traj_fraction >= ONE_Q24)
                    begin
                        traj_fraction = 0;
                        traj_segment  = traj_segment + 1;
                        if (traj_segment >= traj_segments)
                        begin
                            traj_reached = 1'b1;
                            traj_segment = traj_segments - 1;
                        end
                    end
                end
            end
        endcase
    endtask

    // one input beat; valid stays high on return so the next beat can follow at once
    task automatic send_item(input logic [1:0] op, input int row, input int col,
                             input logic [POS_W-1:0] coord, input int cnt);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        waypoint_index <= ROW_W'(row);
        joint_index    <= JOINT_W'(col);
        coordinate     <= coord;
        waypoint_count <= COUNT_W'(cnt);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_positions(op, row, col, coord, cnt);
        items_sent++;
    endtask

    // a tick would read rows that were never loaded: stop the trajectory instead
    task automatic send_tick();
        if (traj_reached || (row_loaded(traj_segment) && row_loaded(traj_segment + 1)))
        begin
            send_item(OP_TICK, $urandom_range(63), $urandom_range(15), $urandom,
                      $urandom_range(127));
            ticks_sent++;
        end
        else
        begin
            send_item(OP_CLEAR, $urandom_range(63), $urandom_range(15), $urandom,
                      $urandom_range(127));
        end
    endtask

    task automatic send_start(input int cnt);
        int n;
        n = cnt;
        if (n >= 2 && !(row_loaded(0) && row_loaded(1)))
            n = $urandom_range(1);
        send_item(OP_START, $urandom_range(63), $urandom_range(15), $urandom, n);
        starts_sent++;
    endtask

    task automatic maybe_noise();
        if ($urandom_range(99) < 6)
        begin
            case ($urandom_range(2))
                0: send_item(OP_LOAD, $urandom_range(63), $urandom_range(JOINTS, 15),
                             $urandom, $urandom_range(127));
                1: send_item(OP_LOAD, $urandom_range(63), $urandom_range(JOINTS - 1),
                             $urandom, $urandom_range(127));
                default: send_start(0);
            endcase
        end
    endtask

    // rows 0..rows-1, each a random step of about 2^scale from the one before; flat: row 1 = row 0
    task automatic load_path(input int rows, input int scale, input bit flat);
        logic [POS_W-1:0] cur [JOINTS];
        for (int j = 0; j < JOINTS; j++)
            cur[j] = $urandom_range(1) ? POS_W'($urandom) : POS_W'($signed($urandom) >>> 10);
        for (int r = 0; r < rows; r++)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                if (r > 0 && !(flat && r == 1))
                    cur[j] = cur[j] + POS_W'($signed($urandom) >>> (31 - scale));
                maybe_noise();
                send_item(OP_LOAD, r, j, cur[j], $urandom_range(127));
            end
        end
    endtask

    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_SPEED)
            speed_reg = data;
        else
            time_step_reg = data;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] spd, input logic [CFG_W-1:0] ts);
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_TIME_STEP, ts);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_trajectory();
        int rows;
        int cnt;
        int pick;
        rows = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 5);
        load_path(rows, $urandom_range(31), $urandom_range(9) == 0);
        case ($urandom_range(9))
            0:       cnt = 0;
            1:       cnt = $urandom_range(WAYPOINTS, 127);
            2:       cnt = $urandom_range(1, 127);
            default: cnt = rows;
        endcase
        send_start(cnt);
        repeat ($urandom_range(2, 14))
        begin
            maybe_noise();
            pick = $urandom_range(99);
            if (pick < 5)
                send_item(OP_CLEAR, $urandom_range(63), $urandom_range(15), $urandom,
                          $urandom_range(127));
            else if (pick < 9)
                send_start(rows);
            send_tick();
        end
    endtask

    task automatic test_after_reset();
        send_tick();
        send_start(0);
        send_start(1);
        send_item(OP_CLEAR, 0, 0, '0, 0);
        send_tick();
    endtask

    // full-scale coordinates of both signs across the first segment
    task automatic test_extreme_segment();
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        for (int j = 0; j < JOINTS; j++)
        begin
            lo = (j % 3 == 0) ? 32'h8000_0000 : (j % 3 == 1) ? 32'h7FFF_FFFF : '0;
            hi = (j % 3 == 0) ? 32'h7FFF_FFFF : (j % 3 == 1) ? 32'h8000_0000 : $urandom;
            send_item(OP_LOAD, 0, j, lo, 0);
            send_item(OP_LOAD, 1, j, hi, 0);
        end
        send_item(OP_LOAD, 63, 14, 32'hFFFF_FFFF, 127);
        send_item(OP_LOAD, 0, 15, 32'h8000_0000, 64);
        send_start(2);
        repeat (3) send_tick();
        wait_drained(8);
        set_config(CFG_MAX, CFG_MAX);
        send_start(127);
        repeat (4) send_tick();
        send_item(OP_CLEAR, 0, 0, '0, 0);
        send_tick();
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] spd, input logic [CFG_W-1:0] ts,
                             input bit quiet, input int target);
        int first;
        wait_drained(8);
        set_config(spd, ts);
        calm  = quiet;
        first = items_sent;
        while (items_sent - first < target)
            random_trajectory();
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        position_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_positions.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: joint %0d pos %h last %b status %0d",
                             joint_out, position, last, status);
            end
            else
            begin
                want = pending_positions.pop_front();
                if (joint_out !== want.joint || position !== want.pos ||
                    last !== want.last || status !== want.status)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("beat %0d: expected joint %0d pos %h last %b status %0d",
                                 beats_checked, want.joint, want.pos, want.last,
                                 want.status);
                        $display("beat %0d: got joint %0d pos %h last %b status %0d",
                                 beats_checked, joint_out, position, last, status);
                    end
                end
            end
            beats_checked++;
        end
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        traj_segment  = 0;
        traj_segments = 0;
        traj_fraction = 0;
        traj_step     = ONE_Q24;
        traj_reached  = 1'b1;
        speed_reg     = SPEED_RST;
        time_step_reg = TIME_STEP_RST;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_table[i] = '0;
            loaded[i]       = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_extreme_segment();
        run_phase(SPEED_RST, TIME_STEP_RST, 1'b0, 20);
        run_phase(CFG_MAX, CFG_MAX, 1'b1, 20);
        run_phase('0, CFG_W'($urandom), 1'b0, 20);
        run_phase(CFG_W'($urandom), '0, 1'b0, 20);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), 1'b0, 20);
        run_phase(CFG_W'(1), CFG_W'(1), 1'b0, 20);

        wait_drained(70);
        $display("%0d items sent (%0d ticks, %0d starts), %0d result beats checked",
                 items_sent, ticks_sent, starts_sent, beats_checked);
        $display("covered: reset state, extreme segments, random trajectories under six settings");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
